FILE: rtl/velocity_ramp_point_mover_assert.svh
// Assertion macros for the point mover
`ifndef VELOCITY_RAMP_POINT_MOVER_ASSERT_SVH
`define VELOCITY_RAMP_POINT_MOVER_ASSERT_SVH

`ifndef SYNTHESIS
`define VRPM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("vrpm assertion failed");
`define VRPM_ASSERT_IMPL(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("vrpm implication failed");
`else
`define VRPM_ASSERT(lbl, prop)
`define VRPM_ASSERT_IMPL(lbl, pre, post)
`endif

`endif

FILE: rtl/vrpm_pkg.sv
package vrpm_pkg;

  localparam int unsigned COORD_BITS = 16;
  localparam int unsigned SPEED_W    = 16;
  localparam int unsigned CNT_W      = $clog2(SPEED_W);
  localparam int unsigned DELTA_W    = COORD_BITS + 1;
  localparam int unsigned MUL_B_W    = (COORD_BITS > SPEED_W + 1) ? COORD_BITS : SPEED_W + 1;
  localparam int unsigned PROD_W     = SPEED_W + MUL_B_W;
  localparam int unsigned NUM_W      = PROD_W + 1;
  localparam int unsigned BRAKE_W    = 2 * SPEED_W;
  localparam int unsigned CMP_W      = (COORD_BITS > BRAKE_W + 1) ? COORD_BITS : BRAKE_W + 1;
  localparam int unsigned SUM_W      =
      ((COORD_BITS > SPEED_W + 1) ? COORD_BITS : SPEED_W + 1) + 1;

  localparam logic [SPEED_W-1:0] SPEED_MAX = '1;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] current_x;
    logic signed [COORD_BITS-1:0] current_y;
    logic signed [COORD_BITS-1:0] goal_x;
    logic signed [COORD_BITS-1:0] goal_y;
  } vrpm_in_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] next_x;
    logic signed [COORD_BITS-1:0] next_y;
  } vrpm_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_BRAKE,
    ST_UPDATE,
    ST_MULT,
    ST_NUMER,
    ST_DIV,
    ST_DONE
  } vrpm_state_e;

endpackage

FILE: rtl/velocity_ramp_point_mover.sv
// Channel  Handshake               Payload
// in       in_valid_i / in_ready_o  in_data_i  (current_x, current_y, goal_x, goal_y)
// out      out_valid_o / out_ready_i out_data_o (next_x, next_y)
//
// Each accepted transaction runs three bit-serial passes on narrow datapaths (brake
// product, minor product, minor quotient) between its control states; in_ready_o returns
// in the same cycle as the new result appears in the output register.
// One transaction is in flight at a time; in_ready_o is high only when idle.
// A finished result waits in the output register while the next transaction is taken;
// the next result stalls until that register has been emptied by out_ready_i.
// Reset clears speed to zero and empties the output register.
module velocity_ramp_point_mover (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  vrpm_pkg::vrpm_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output vrpm_pkg::vrpm_out_t out_data_o
);
  import vrpm_pkg::*;

  `include "velocity_ramp_point_mover_assert.svh"

  vrpm_state_e            state_q, state_d;
  vrpm_in_t               in_q;
  logic [SPEED_W-1:0]     speed_q, speed_d;
  logic                   major_x_q, maj_neg_q, min_neg_q, min_nz_q, has_major_q;
  logic [COORD_BITS-1:0]  maj_mag_q, min_mag_q;
  vrpm_out_t              out_q, out_d;
  logic                   out_valid_q, out_valid_d;

  logic signed [DELTA_W-1:0] dx, dy;
  logic [COORD_BITS-1:0]     ax, ay;
  logic                      pick_x;

  logic                  mul_start, mul_done;
  logic [SPEED_W-1:0]    mul_a;
  logic [MUL_B_W-1:0]    mul_b;
  logic [PROD_W-1:0]     mul_prod;
  logic                  div_start, div_done;
  logic [NUM_W-1:0]      div_num, prod_ext, half_ext;
  logic [SPEED_W-1:0]    div_quo;

  logic [BRAKE_W-1:0]    brake;
  logic [CMP_W-1:0]      dist_ext, brake_ext, thresh_ext;
  logic                  do_inc, do_dec;

  logic signed [SUM_W-1:0] step_s, minor_s, maj_sum, min_sum;
  logic [COORD_BITS-1:0]   maj_sat, min_sat;
  logic                    load_out;

  function automatic logic [COORD_BITS-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = $signed({{(SUM_W-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}});
    lo = -hi - SUM_W'(1);
    if (v > hi) begin
      return hi[COORD_BITS-1:0];
    end else if (v < lo) begin
      return lo[COORD_BITS-1:0];
    end
    return v[COORD_BITS-1:0];
  endfunction

  // deltas and magnitudes
  always_comb begin
    dx = $signed({in_q.goal_x[COORD_BITS-1], in_q.goal_x})
       - $signed({in_q.current_x[COORD_BITS-1], in_q.current_x});
    dy = $signed({in_q.goal_y[COORD_BITS-1], in_q.goal_y})
       - $signed({in_q.current_y[COORD_BITS-1], in_q.current_y});
    ax = dx[COORD_BITS] ? COORD_BITS'(-dx) : COORD_BITS'(dx);
    ay = dy[COORD_BITS] ? COORD_BITS'(-dy) : COORD_BITS'(dy);
    pick_x = ax > ay;
  end

  // speed ramp decision
  always_comb begin
    brake      = mul_prod[BRAKE_W:1];
    dist_ext   = CMP_W'(maj_mag_q);
    brake_ext  = CMP_W'(brake);
    thresh_ext = brake_ext + CMP_W'(speed_q);
    do_inc     = dist_ext > thresh_ext;
    do_dec     = dist_ext < brake_ext;
  end

  // minor numerator |V*B +/- floor(A/2)|
  always_comb begin
    prod_ext = NUM_W'(mul_prod);
    half_ext = NUM_W'(maj_mag_q >> 1);
    if (!min_neg_q) begin
      div_num = prod_ext + half_ext;
    end else if (prod_ext >= half_ext) begin
      div_num = prod_ext - half_ext;
    end else begin
      div_num = half_ext - prod_ext;
    end
  end

  // result assembly
  always_comb begin
    step_s  = $signed(SUM_W'(speed_q));
    if (!has_major_q) begin
      step_s = '0;
    end else if (maj_neg_q) begin
      step_s = -step_s;
    end
    minor_s = $signed(SUM_W'(div_quo));
    if (!min_nz_q) begin
      minor_s = '0;
    end else if (min_neg_q) begin
      minor_s = -minor_s;
    end
    if (major_x_q) begin
      maj_sum = $signed(SUM_W'(in_q.current_x)) + step_s;
      min_sum = $signed(SUM_W'(in_q.current_y)) + minor_s;
    end else begin
      maj_sum = $signed(SUM_W'(in_q.current_y)) + step_s;
      min_sum = $signed(SUM_W'(in_q.current_x)) + minor_s;
    end
    maj_sat = sat_coord(maj_sum);
    min_sat = sat_coord(min_sum);
    out_d.next_x = major_x_q ? maj_sat : min_sat;
    out_d.next_y = major_x_q ? min_sat : maj_sat;
  end

  always_comb begin
    state_d     = state_q;
    speed_d     = speed_q;
    mul_start   = 1'b0;
    mul_a       = speed_q;
    mul_b       = MUL_B_W'(speed_q) + MUL_B_W'(1);
    div_start   = 1'b0;
    load_out    = 1'b0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        mul_start = 1'b1;
        state_d   = ST_BRAKE;
      end
      ST_BRAKE: begin
        if (mul_done) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (do_inc && speed_q != SPEED_MAX) begin
          speed_d = speed_q + SPEED_W'(1);
        end else if (do_dec && speed_q != '0) begin
          speed_d = speed_q - SPEED_W'(1);
        end
        mul_start = 1'b1;
        mul_a     = speed_d;
        mul_b     = MUL_B_W'(min_mag_q);
        state_d   = ST_MULT;
      end
      ST_MULT: begin
        if (mul_done) begin
          state_d = ST_NUMER;
        end
      end
      ST_NUMER: begin
        div_start = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          load_out    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      speed_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      speed_q     <= speed_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (state_q == ST_PREP) begin
      major_x_q   <= pick_x;
      maj_mag_q   <= pick_x ? ax : ay;
      min_mag_q   <= pick_x ? ay : ax;
      maj_neg_q   <= pick_x ? dx[COORD_BITS] : dy[COORD_BITS];
      min_neg_q   <= pick_x ? dy[COORD_BITS] : dx[COORD_BITS];
      min_nz_q    <= (pick_x ? ay : ax) != '0;
      has_major_q <= (pick_x ? ax : ay) != '0;
    end
    if (load_out) begin
      out_q <= out_d;
    end
  end

  vrpm_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  vrpm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (maj_mag_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `VRPM_ASSERT(a_speed_moves_by_one, (speed_q != $past(speed_q)) |-> ((speed_q == $past(speed_q) + SPEED_W'(1)) || (speed_q == $past(speed_q) - SPEED_W'(1))))
  `VRPM_ASSERT(a_speed_only_in_update, (speed_q != $past(speed_q)) |-> ($past(state_q) == ST_UPDATE))
  `VRPM_ASSERT(a_result_from_done, $rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
  `VRPM_ASSERT_IMPL(a_mul_done_awaited, mul_done, (state_q == ST_BRAKE || state_q == ST_MULT))
  `VRPM_ASSERT_IMPL(a_div_done_awaited, div_done, state_q == ST_DIV)

endmodule

FILE: rtl/vrpm_mul.sv
module vrpm_mul (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [vrpm_pkg::SPEED_W-1:0]  a_i,
  input  logic [vrpm_pkg::MUL_B_W-1:0]  b_i,
  output logic                          done_o,
  output logic [vrpm_pkg::PROD_W-1:0]   prod_o
);
  import vrpm_pkg::*;

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [PROD_W-1:0]   acc_q, acc_d;
  logic [MUL_B_W-1:0]  b_q, b_d;
  logic [MUL_B_W:0]    sum;

  // shift-add, one multiplier bit per cycle
  always_comb begin
    sum    = {1'b0, acc_q[PROD_W-1 -: MUL_B_W]} + (acc_q[0] ? {1'b0, b_q} : '0);
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    b_d    = b_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      acc_d  = {{MUL_B_W{1'b0}}, a_i};
      b_d    = b_i;
    end else if (busy_q) begin
      acc_d = {sum, acc_q[SPEED_W-1:1]};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(SPEED_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    b_q   <= b_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

FILE: rtl/vrpm_div.sv
module vrpm_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [vrpm_pkg::NUM_W-1:0]      num_i,
  input  logic [vrpm_pkg::COORD_BITS-1:0] den_i,
  output logic                            done_o,
  output logic [vrpm_pkg::SPEED_W-1:0]    quo_o
);
  import vrpm_pkg::*;

  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [COORD_BITS-1:0]  rem_q, rem_d;
  logic [COORD_BITS-1:0]  den_q, den_d;
  logic [SPEED_W-1:0]     sh_q, sh_d;
  logic [COORD_BITS:0]    trial;
  logic [COORD_BITS+1:0]  diff;
  logic                   ge;

  // restoring division, one quotient bit per cycle; quotient fits SPEED_W bits
  always_comb begin
    trial  = {rem_q, sh_q[SPEED_W-1]};
    diff   = {1'b0, trial} - {2'b00, den_q};
    ge     = ~diff[COORD_BITS+1];
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    sh_d   = sh_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = num_i[SPEED_W +: COORD_BITS];
      sh_d   = num_i[SPEED_W-1:0];
      den_d  = den_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
      sh_d  = {sh_q[SPEED_W-2:0], ge};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(SPEED_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    sh_q  <= sh_d;
  end

  assign done_o = done_q;
  assign quo_o  = sh_q;

endmodule

FILE: sim/tb_velocity_ramp_point_mover.sv
`timescale 1ns / 1ps

module tb_velocity_ramp_point_mover;
  import vrpm_pkg::*;

  typedef struct packed {
    vrpm_in_t  stim;
    logic      known;
    vrpm_out_t want;
  } dir_row_t;

  localparam int DIR_ROWS = 21;
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, '{16'sd0, 16'sd0}},
    '{'{16'sd100, 16'sd0, 16'sd200, 16'sd0}, 1'b1, '{16'sd101, 16'sd0}},
    '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, '{16'sd0, 16'sd0}},
    '{'{16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000}, 1'b0, '{16'sd0, 16'sd0}},
    '{'{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff}, 1'b0, '{16'sd0, 16'sd0}},
    '{'{16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000}, 1'b0, '{16'sd0, 16'sd0}},
    '{'{16'sd0, 16'sd0, 16'sd0, -16'sd300}, 1'b0, '{16'sd0, 16'sd0}},
    '{'{16'sd0, 16'sd0, 16'sd30000, 16'sd1000}, 1'b0, '{16'sd0, 16'sd0}},
    '{'{16'sd0, 16'sd0, 16'sd30000, 16'sd1000}, 1'b0, '{16'sd0, 16'sd0}},
    '{'{16'sd0, 16'sd0, 16'sd30000, 16'sd1000}, 1'b0, '{16'sd0, 16'sd0}},
    '{'{16'sd0, 16'sd0, 16'sd30000, 16'sd1000}, 1'b0, '{16'sd0, 16'sd0}},
    '{'{16'sd0, 16'sd0, 16'sd30000, 16'sd1000}, 1'b0, '{16'sd0, 16'sd0}},
    '{'{16'sd0, 16'sd0, 16'sd30000, 16'sd1000}, 1'b0, '{16'sd0, 16'sd0}},
    '{'{16'sh7ffd, 16'sd0, 16'sh7fff, 16'sd0}, 1'b1, '{16'sh7fff, 16'sd0}},
    '{'{16'sh8003, 16'sd5, 16'sh8001, 16'sd4}, 1'b0, '{16'sd0, 16'sd0}},
    '{'{16'sd0, 16'sd0, -16'sd50, 16'sd50}, 1'b0, '{16'sd0, 16'sd0}},
    '{'{16'sd0, 16'sd0, -16'sd50, -16'sd49}, 1'b0, '{16'sd0, 16'sd0}},
    '{'{16'sd0, 16'sh7ffe, 16'sd1, 16'sh7fff}, 1'b0, '{16'sd0, 16'sd0}},
    '{'{16'sd0, 16'sh8001, 16'sd2, 16'sh8000}, 1'b0, '{16'sd0, 16'sd0}},
    '{'{16'sd1234, -16'sd1234, 16'sd1234, -16'sd1234}, 1'b0, '{16'sd0, 16'sd0}},
    '{'{16'sd0, 16'sd0, 16'sd1, 16'sd0}, 1'b0, '{16'sd0, 16'sd0}}
  };

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  vrpm_in_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  vrpm_out_t out_data_o;

  vrpm_out_t         pending_points [$];
  logic [SPEED_W-1:0] speed_q = '0;
  int                tx_idle_pct = 0;
  int                rx_idle_pct = 0;
  int                moves_sent = 0;
  int                moves_checked = 0;
  int                mismatches = 0;
  int                top_speed = 0;
  int                clamped_moves = 0;

  velocity_ramp_point_mover dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic longint clamp_coord(input longint c);
    longint hi, lo;
    hi = (longint'(1) << (COORD_BITS - 1)) - 1;
    lo = -hi - 1;
    if (c > hi) return hi;
    if (c < lo) return lo;
    return c;
  endfunction

  function automatic longint minor_offset(input longint s, input longint dmaj,
                                          input longint dmin);
    longint q, m;
    q = (s * dmin + dmaj / 2) / dmaj;
    m = (q < 0) ? -q : q;
    return (dmin > 0) ? m : -m;
  endfunction

  // one step of the ramp; updates the tracked speed
  function automatic vrpm_out_t move_point(input vrpm_in_t p);
    longint cx, cy, dx, dy, ax, ay, span, v, brake, s, nx, ny;
    vrpm_out_t r;
    cx = longint'(p.current_x);
    cy = longint'(p.current_y);
    dx = longint'(p.goal_x) - cx;
    dy = longint'(p.goal_y) - cy;
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    span = (ax > ay) ? ax : ay;
    v = longint'(speed_q);
    brake = (v * (v + 1)) / 2;
    nx = cx;
    ny = cy;
    if (span >= brake + v + 1) begin
      if (v < longint'(SPEED_MAX)) v = v + 1;
    end else if (span < brake) begin
      if (v > 0) v = v - 1;
    end
    speed_q = v[SPEED_W-1:0];
    if (int'(v) > top_speed) top_speed = int'(v);
    if (ax > ay) begin
      s = (dx > 0) ? v : -v;
      nx = cx + s;
      if (dy != 0) ny = cy + minor_offset(s, dx, dy);
    end else if (dy != 0) begin
      s = (dy > 0) ? v : -v;
      ny = cy + s;
      if (dx != 0) nx = cx + minor_offset(s, dy, dx);
    end
    if (clamp_coord(nx) != nx || clamp_coord(ny) != ny) clamped_moves++;
    r.next_x = COORD_BITS'(clamp_coord(nx));
    r.next_y = COORD_BITS'(clamp_coord(ny));
    return r;
  endfunction

  task automatic send_move(input vrpm_in_t item, input logic known, input vrpm_out_t want,
                           output vrpm_out_t predicted);
    predicted = move_point(item);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    pending_points.push_back(known ? want : predicted);
    moves_sent++;
  endtask

  task automatic drain_moves();
    in_valid_i <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk_i);
  endtask

  // chase a goal that is nudged now and then, feeding each new point back as the current point
  task automatic run_path();
    vrpm_in_t  p;
    vrpm_out_t nxt;
    int        steps;
    p = {$urandom, $urandom};
    if ($urandom_range(4) != 0) begin
      p.goal_x = COORD_BITS'(clamp_coord(longint'(p.current_x)
                                         + longint'($urandom_range(4000)) - 2000));
      p.goal_y = COORD_BITS'(clamp_coord(longint'(p.current_y)
                                         + longint'($urandom_range(4000)) - 2000));
    end
    steps = $urandom_range(150, 20);
    for (int i = 0; i < steps; i++) begin
      if ($urandom_range(19) == 0) begin
        p.goal_x = COORD_BITS'(clamp_coord(longint'(p.goal_x)
                                           + longint'($urandom_range(200)) - 100));
        p.goal_y = COORD_BITS'(clamp_coord(longint'(p.goal_y)
                                           + longint'($urandom_range(200)) - 100));
      end
      send_move(p, 1'b0, '0, nxt);
      if (nxt.next_x == p.goal_x && nxt.next_y == p.goal_y && speed_q == '0) break;
      p.current_x = nxt.next_x;
      p.current_y = nxt.next_y;
    end
    if ($urandom_range(19) == 0) drain_moves();
  endtask

  task automatic run_random(input int quota);
    int        stop_at;
    int        pick;
    vrpm_in_t  p;
    vrpm_out_t nxt;
    stop_at = moves_sent + quota;
    while (moves_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        run_path();
      end else if (pick < 88) begin
        p = {$urandom, $urandom};
        send_move(p, 1'b0, '0, nxt);
      end else begin
        p = {$urandom, $urandom};
        p.goal_x = COORD_BITS'(clamp_coord(longint'(p.current_x)
                                           + longint'($urandom_range(6)) - 3));
        p.goal_y = COORD_BITS'(clamp_coord(longint'(p.current_y)
                                           + longint'($urandom_range(6)) - 3));
        send_move(p, 1'b0, '0, nxt);
      end
    end
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk_i) begin : check_moves
    vrpm_out_t want_pt;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_points.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected transaction, actual x=%0d y=%0d", $time,
                 out_data_o.next_x, out_data_o.next_y);
      end else begin
        want_pt = pending_points.pop_front();
        moves_checked++;
        if (out_data_o.next_x !== want_pt.next_x) begin
          mismatches++;
          $display("%0t: next_x expected %0d actual %0d", $time,
                   want_pt.next_x, out_data_o.next_x);
        end
        if (out_data_o.next_y !== want_pt.next_y) begin
          mismatches++;
          $display("%0t: next_y expected %0d actual %0d", $time,
                   want_pt.next_y, out_data_o.next_y);
        end
      end
    end
  end

  initial begin
    vrpm_out_t nxt;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle_pct = 25;
    rx_idle_pct = 83;
    for (int i = 0; i < DIR_ROWS; i++) begin
      send_move(DIR_TABLE[i].stim, DIR_TABLE[i].known, DIR_TABLE[i].want, nxt);
    end
    run_random(540);
    drain_moves();

    tx_idle_pct = 83;
    rx_idle_pct = 25;
    run_random(560);
    drain_moves();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random(560);

    drain_moves();
    repeat (60) @(posedge clk_i);

    $display("summary: %0d moves sent, %0d checked, top speed %0d, %0d clamped at the edge",
             moves_sent, moves_checked, top_speed, clamped_moves);
    $display("summary: ramps, overshoot, goal reached and random points under three idle mixes");
    if (mismatches == 0 && pending_points.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
